// ===== hdl/tlnps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tlnps_pkg;

   // Field widths of the request and response items
   localparam int ACTION_W   = 2;
   localparam int GRP_IDX_W  = 6;
   localparam int SLOT_IDX_W = 4;
   localparam int COORD_W    = 32;
   localparam int GCOUNT_W   = 7;

   // Default sizes of the anchor table and of each point group
   localparam int DEF_MAX_GROUPS = 64;
   localparam int DEF_MAX_POINTS = 16;

   // Request actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_ANCHOR_WR = 2'd0,
      ACT_POINT_WR  = 2'd1,
      ACT_QUERY     = 2'd2
   } action_type;

   // Flavor of a response loaded into the output register
   typedef enum logic [1:0] {
      RES_NONE  = 2'd0,
      RES_GROUP = 2'd1,
      RES_POINT = 2'd2
   } result_kind_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic            clr_en;
      logic            wr_anchor;
      logic            wr_point;
      logic            load_query;
      logic            scan_start;
      logic            anchor_issue;
      logic            cnt_read;
      logic            point_issue;
      logic            fetch;
      logic            load_result;
      result_kind_type result_kind;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clr_last;
      logic table_empty;
      logic last_anchor;
      logic last_point;
      logic pipe_busy;
      logic cnt_zero;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

// ===== hdl/tlnps_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface tlnps_req_if;
   import tlnps_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   logic [GRP_IDX_W-1:0]  group_index;
   logic [SLOT_IDX_W-1:0] slot_index;
   logic [COORD_W-1:0]    coord_x;
   logic [COORD_W-1:0]    coord_y;
   logic [COORD_W-1:0]    coord_z;

   modport source (output valid, action, group_index, slot_index,
                   coord_x, coord_y, coord_z, input ready);
   modport sink   (input valid, action, group_index, slot_index,
                   coord_x, coord_y, coord_z, output ready);
endinterface
`default_nettype wire

// ===== hdl/tlnps_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface tlnps_rsp_if;
   import tlnps_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [GRP_IDX_W-1:0]  nearest_group;
   logic [SLOT_IDX_W-1:0] nearest_slot;
   logic [COORD_W-1:0]    point_x;
   logic [COORD_W-1:0]    point_y;
   logic [COORD_W-1:0]    point_z;
   logic                  found;

   modport source (output valid, nearest_group, nearest_slot, point_x, point_y,
                   point_z, found, input ready);
   modport sink   (input valid, nearest_group, nearest_slot, point_x, point_y,
                   point_z, found, output ready);
endinterface
`default_nettype wire

// ===== hdl/tlnps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tlnps_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic [tlnps_pkg::ACTION_W-1:0] req_action,
   output logic                        req_ready,
   input  wire tlnps_pkg::status_type  status,
   output tlnps_pkg::cmd_type          cmd
);
   import tlnps_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ANCHOR,
      ST_ADRAIN,
      ST_CNT_RD,
      ST_CNT_CHK,
      ST_POINT,
      ST_PDRAIN,
      ST_FETCH,
      ST_EMIT_NONE,
      ST_EMIT_GROUP,
      ST_EMIT_POINT
   } state_type;

   state_type state_ff, state_in;
   logic      req_acc;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;

   // Decode commands and next state
   always_comb begin
      cmd         = '0;
      cmd.result_kind = RES_NONE;
      state_in    = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_acc) begin
               case (req_action)
                  ACT_ANCHOR_WR: cmd.wr_anchor = 1'b1;
                  ACT_POINT_WR:  cmd.wr_point  = 1'b1;
                  ACT_QUERY: begin
                     cmd.load_query = 1'b1;
                     cmd.scan_start = 1'b1;
                     state_in = status.table_empty ? ST_EMIT_NONE : ST_ANCHOR;
                  end
                  default: ;
               endcase
            end
         end
         ST_ANCHOR: begin
            cmd.anchor_issue = 1'b1;
            if (status.last_anchor) state_in = ST_ADRAIN;
         end
         ST_ADRAIN: begin
            if (!status.pipe_busy) state_in = ST_CNT_RD;
         end
         ST_CNT_RD: begin
            cmd.cnt_read = 1'b1;
            state_in = ST_CNT_CHK;
         end
         ST_CNT_CHK: begin
            cmd.scan_start = 1'b1;
            state_in = status.cnt_zero ? ST_EMIT_GROUP : ST_POINT;
         end
         ST_POINT: begin
            cmd.point_issue = 1'b1;
            if (status.last_point) state_in = ST_PDRAIN;
         end
         ST_PDRAIN: begin
            if (!status.pipe_busy) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in = ST_EMIT_POINT;
         end
         ST_EMIT_NONE: begin
            cmd.result_kind = RES_NONE;
            if (status.rsp_free) begin
               cmd.load_result = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_GROUP: begin
            cmd.result_kind = RES_GROUP;
            if (status.rsp_free) begin
               cmd.load_result = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_POINT: begin
            cmd.result_kind = RES_POINT;
            if (status.rsp_free) begin
               cmd.load_result = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/tlnps_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tlnps_dp #(
   parameter int MAX_GROUPS = tlnps_pkg::DEF_MAX_GROUPS,
   parameter int MAX_POINTS = tlnps_pkg::DEF_MAX_POINTS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire tlnps_pkg::cmd_type              cmd,
   output tlnps_pkg::status_type                status,
   input  wire logic                            csr_we,
   input  wire logic [tlnps_pkg::GCOUNT_W-1:0]  csr_wdata,
   input  wire logic [tlnps_pkg::GRP_IDX_W-1:0] req_group_index,
   input  wire logic [tlnps_pkg::SLOT_IDX_W-1:0] req_slot_index,
   input  wire logic [tlnps_pkg::COORD_W-1:0]   req_coord_x,
   input  wire logic [tlnps_pkg::COORD_W-1:0]   req_coord_y,
   input  wire logic [tlnps_pkg::COORD_W-1:0]   req_coord_z,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic [tlnps_pkg::GRP_IDX_W-1:0]      rsp_nearest_group,
   output logic [tlnps_pkg::SLOT_IDX_W-1:0]     rsp_nearest_slot,
   output logic [tlnps_pkg::COORD_W-1:0]        rsp_point_x,
   output logic [tlnps_pkg::COORD_W-1:0]        rsp_point_y,
   output logic [tlnps_pkg::COORD_W-1:0]        rsp_point_z,
   output logic                                 rsp_found
);
   import tlnps_pkg::*;

   localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int SW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int IW    = (GW > SW) ? GW : SW;
   localparam int DEPTH = MAX_GROUPS * MAX_POINTS;
   localparam int PAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW  = $clog2(MAX_POINTS + 1);
   localparam int CW    = COORD_W;
   localparam int DW    = 2 * CW + 2;

   // Storage
   logic [CW-1:0]   anc_x_mem [MAX_GROUPS];
   logic [CW-1:0]   anc_z_mem [MAX_GROUPS];
   logic [CW-1:0]   pt_x_mem  [DEPTH];
   logic [CW-1:0]   pt_y_mem  [DEPTH];
   logic [CW-1:0]   pt_z_mem  [DEPTH];
   logic [CNTW-1:0] cnt_mem   [MAX_GROUPS];

   logic [GCOUNT_W-1:0] gc_ff;
   logic [GW-1:0]       clr_ff;
   logic [IW-1:0]       scan_ff;
   logic [CW-1:0]       q_x_ff, q_y_ff, q_z_ff;
   logic [CW-1:0]       anc_x_rd_ff, anc_z_rd_ff;
   logic [CW-1:0]       pt_x_rd_ff, pt_y_rd_ff, pt_z_rd_ff;
   logic [CNTW-1:0]     cnt_rd_ff;

   // Pipeline tags
   logic          s1_v_ff, s2_v_ff, s3_v_ff;
   logic          s1_anc_ff, s2_anc_ff, s3_anc_ff;
   logic [IW-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff;

   logic [CW-1:0]   ad_x_ff, ad_y_ff, ad_z_ff;
   logic [CW-1:0]   ad_x_in, ad_y_in, ad_z_in;
   logic [2*CW-1:0] sq_x_ff, sq_y_ff, sq_z_ff;
   logic [DW-1:0]   dist_in, best_d_ff;
   logic [GW-1:0]   best_g_ff;
   logic [SW-1:0]   best_s_ff;

   logic                  rsp_valid_ff;
   logic [GRP_IDX_W-1:0]  rsp_group_ff;
   logic [SLOT_IDX_W-1:0] rsp_slot_ff;
   logic [CW-1:0]         rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                  rsp_found_ff;

   logic [31:0]     wr_g_wide, wr_s_wide, wr_pt_addr_wide;
   logic [31:0]     scan_pt_addr_wide, best_pt_addr_wide, n_wide;
   logic            wr_g_ok, wr_s_ok;
   logic [GW-1:0]   wr_g;
   logic [PAW-1:0]  wr_pt_addr, scan_pt_addr, best_pt_addr;
   logic [CW-1:0]   op_x, op_y, op_z;

   // Decode write addresses and range checks
   assign wr_g_wide       = 32'(req_group_index);
   assign wr_s_wide       = 32'(req_slot_index);
   assign wr_g_ok         = wr_g_wide < 32'(MAX_GROUPS);
   assign wr_s_ok         = wr_s_wide < 32'(MAX_POINTS);
   assign wr_g            = wr_g_wide[GW-1:0];
   assign wr_pt_addr_wide = wr_g_wide * 32'(MAX_POINTS) + wr_s_wide;
   assign wr_pt_addr      = wr_pt_addr_wide[PAW-1:0];

   // Clamp the group count to the table size
   assign n_wide = (32'(gc_ff) > 32'(MAX_GROUPS)) ? 32'(MAX_GROUPS) : 32'(gc_ff);

   // Point addresses for the scan and for the final fetch
   assign scan_pt_addr_wide = 32'(best_g_ff) * 32'(MAX_POINTS) + 32'(scan_ff);
   assign scan_pt_addr      = scan_pt_addr_wide[PAW-1:0];
   assign best_pt_addr_wide = 32'(best_g_ff) * 32'(MAX_POINTS) + 32'(best_s_ff);
   assign best_pt_addr      = best_pt_addr_wide[PAW-1:0];

   // Anchor memories: write from requests, read during the anchor scan
   always_ff @(posedge clock) begin
      if (cmd.wr_anchor && wr_g_ok) begin
         anc_x_mem[wr_g] <= req_coord_x;
         anc_z_mem[wr_g] <= req_coord_z;
      end
      if (cmd.anchor_issue) begin
         anc_x_rd_ff <= anc_x_mem[scan_ff[GW-1:0]];
         anc_z_rd_ff <= anc_z_mem[scan_ff[GW-1:0]];
      end
   end

   // Point memories: write from requests, read during the point scan and fetch
   always_ff @(posedge clock) begin
      if (cmd.wr_point && wr_g_ok && wr_s_ok) begin
         pt_x_mem[wr_pt_addr] <= req_coord_x;
         pt_y_mem[wr_pt_addr] <= req_coord_y;
         pt_z_mem[wr_pt_addr] <= req_coord_z;
      end
      if (cmd.point_issue) begin
         pt_x_rd_ff <= pt_x_mem[scan_pt_addr];
         pt_y_rd_ff <= pt_y_mem[scan_pt_addr];
         pt_z_rd_ff <= pt_z_mem[scan_pt_addr];
      end else if (cmd.fetch) begin
         pt_x_rd_ff <= pt_x_mem[best_pt_addr];
         pt_y_rd_ff <= pt_y_mem[best_pt_addr];
         pt_z_rd_ff <= pt_z_mem[best_pt_addr];
      end
   end

   // Point count memory: cleared by the sweep after reset, set by point writes
   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         cnt_mem[clr_ff] <= '0;
      end else if (cmd.wr_point && wr_g_ok && wr_s_ok) begin
         cnt_mem[wr_g] <= CNTW'(wr_s_wide + 32'd1);
      end
      if (cmd.cnt_read) begin
         cnt_rd_ff <= cnt_mem[best_g_ff];
      end
   end

   // Control counters and the group count register
   always_ff @(posedge clock) begin
      if (reset) begin
         gc_ff   <= '0;
         clr_ff  <= '0;
         scan_ff <= '0;
      end else begin
         if (csr_we) gc_ff <= csr_wdata;
         if (cmd.clr_en) clr_ff <= clr_ff + 1'b1;
         if (cmd.scan_start) begin
            scan_ff <= '0;
         end else if (cmd.anchor_issue || cmd.point_issue) begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
   end

   // Latch the query point
   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         q_x_ff <= req_coord_x;
         q_y_ff <= req_coord_y;
         q_z_ff <= req_coord_z;
      end
   end

   // Stage 1: absolute differences; anchors have y at zero
   assign op_x = s1_anc_ff ? anc_x_rd_ff : pt_x_rd_ff;
   assign op_y = s1_anc_ff ? '0          : pt_y_rd_ff;
   assign op_z = s1_anc_ff ? anc_z_rd_ff : pt_z_rd_ff;

   always_comb begin
      logic [CW:0] dx, dy, dz;
      dx = {q_x_ff[CW-1], q_x_ff} - {op_x[CW-1], op_x};
      dy = {q_y_ff[CW-1], q_y_ff} - {op_y[CW-1], op_y};
      dz = {q_z_ff[CW-1], q_z_ff} - {op_z[CW-1], op_z};
      ad_x_in = dx[CW] ? CW'(-dx) : dx[CW-1:0];
      ad_y_in = dy[CW] ? CW'(-dy) : dy[CW-1:0];
      ad_z_in = dz[CW] ? CW'(-dz) : dz[CW-1:0];
   end

   // Stage 3 sum of squares
   assign dist_in = DW'(sq_x_ff) + DW'(sq_y_ff) + DW'(sq_z_ff);

   // Advance the distance pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.anchor_issue || cmd.point_issue;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_anc_ff <= cmd.anchor_issue;
      s1_idx_ff <= scan_ff;
      s2_anc_ff <= s1_anc_ff;
      s2_idx_ff <= s1_idx_ff;
      s3_anc_ff <= s2_anc_ff;
      s3_idx_ff <= s2_idx_ff;
      ad_x_ff   <= ad_x_in;
      ad_y_ff   <= ad_y_in;
      ad_z_ff   <= ad_z_in;
      sq_x_ff   <= ad_x_ff * ad_x_ff;
      sq_y_ff   <= ad_y_ff * ad_y_ff;
      sq_z_ff   <= ad_z_ff * ad_z_ff;
   end

   // Keep the best so far; the first entry always wins, ties go to the later one
   always_ff @(posedge clock) begin
      if (s3_v_ff && (s3_idx_ff == '0 || dist_in <= best_d_ff)) begin
         best_d_ff <= dist_in;
         if (s3_anc_ff) begin
            best_g_ff <= s3_idx_ff[GW-1:0];
         end else begin
            best_s_ff <= s3_idx_ff[SW-1:0];
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         case (cmd.result_kind)
            RES_GROUP: begin
               rsp_group_ff <= GRP_IDX_W'(32'(best_g_ff));
               rsp_slot_ff  <= '0;
               rsp_x_ff     <= '0;
               rsp_y_ff     <= '0;
               rsp_z_ff     <= '0;
               rsp_found_ff <= 1'b0;
            end
            RES_POINT: begin
               rsp_group_ff <= GRP_IDX_W'(32'(best_g_ff));
               rsp_slot_ff  <= SLOT_IDX_W'(32'(best_s_ff));
               rsp_x_ff     <= pt_x_rd_ff;
               rsp_y_ff     <= pt_y_rd_ff;
               rsp_z_ff     <= pt_z_rd_ff;
               rsp_found_ff <= 1'b1;
            end
            default: begin
               rsp_group_ff <= '0;
               rsp_slot_ff  <= '0;
               rsp_x_ff     <= '0;
               rsp_y_ff     <= '0;
               rsp_z_ff     <= '0;
               rsp_found_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_group = rsp_group_ff;
   assign rsp_nearest_slot  = rsp_slot_ff;
   assign rsp_point_x       = rsp_x_ff;
   assign rsp_point_y       = rsp_y_ff;
   assign rsp_point_z       = rsp_z_ff;
   assign rsp_found         = rsp_found_ff;

   // Status back to the controller
   assign status.clr_last    = (32'(clr_ff) == 32'(MAX_GROUPS - 1));
   assign status.table_empty = (n_wide == 32'd0);
   assign status.last_anchor = (32'(scan_ff) + 32'd1 == n_wide);
   assign status.last_point  = (32'(scan_ff) + 32'd1 == 32'(cnt_rd_ff));
   assign status.pipe_busy   = s1_v_ff || s2_v_ff || s3_v_ff;
   assign status.cnt_zero    = (cnt_rd_ff == '0);
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

// ===== hdl/two_level_nearest_point_search.sv =====
// Two-level nearest point search.
// Requests arrive on req_if (valid/ready): action 0 writes a group anchor (x, z),
// action 1 writes a point into a group slot, action 2 queries the nearest point,
// action 3 is dropped. Writes are taken back to back and give no response.
// A query gives one response on rsp_if: the group with the nearest anchor, the
// nearest point in it, and found; found is 0 when no group is in use or the
// chosen group holds no points. csr_we/csr_wdata set the number of groups in use;
// write it only while no query is in flight.
// A query scans the anchors of the N groups in use, then the C points of the chosen
// group, before rsp_if.valid rises; the anchor and point scans each compare one
// squared distance per cycle through a four-stage read / difference / square /
// compare pipeline. One query is worked at a time.
// After reset a sweep over all MAX_GROUPS entries clears the point counts, with
// req_if.ready low. The response sits in an output register: while the receiver
// stalls, writes are still taken, and a following query runs until its response
// is ready, then waits for the register to empty.
`timescale 1ns / 1ps
`default_nettype none
module two_level_nearest_point_search #(
   parameter int MAX_GROUPS = tlnps_pkg::DEF_MAX_GROUPS,
   parameter int MAX_POINTS = tlnps_pkg::DEF_MAX_POINTS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   tlnps_req_if.sink                           req_if,
   tlnps_rsp_if.source                         rsp_if,
   input  wire logic                           csr_we,
   input  wire logic [tlnps_pkg::GCOUNT_W-1:0] csr_wdata
);
   import tlnps_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_if.ready = req_ready;

   tlnps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_action (req_if.action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   tlnps_dp #(
      .MAX_GROUPS (MAX_GROUPS),
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_group_index   (req_if.group_index),
      .req_slot_index    (req_if.slot_index),
      .req_coord_x       (req_if.coord_x),
      .req_coord_y       (req_if.coord_y),
      .req_coord_z       (req_if.coord_z),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_if.valid),
      .rsp_nearest_group (rsp_if.nearest_group),
      .rsp_nearest_slot  (rsp_if.nearest_slot),
      .rsp_point_x       (rsp_if.point_x),
      .rsp_point_y       (rsp_if.point_y),
      .rsp_point_z       (rsp_if.point_z),
      .rsp_found         (rsp_if.found)
   );

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import tlnps_pkg::*;

   localparam int MAX_GROUPS   = DEF_MAX_GROUPS;
   localparam int MAX_POINTS   = DEF_MAX_POINTS;
   localparam int PHASE_ITEMS  = 80;
   localparam int SETTLE_WAIT  = 120;
   localparam int LONG_HOLD    = 900;
   localparam int IDLE_PERCENT = 21;
   localparam int CYCLE_LIMIT  = 600000;

   // Action code the block drops without a response
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic [ACTION_W-1:0]   action;
      logic [GRP_IDX_W-1:0]  group_index;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic [COORD_W-1:0]    x;
      logic [COORD_W-1:0]    y;
      logic [COORD_W-1:0]    z;
   } request_type;

   typedef struct {
      logic [GRP_IDX_W-1:0]  nearest_group;
      logic [SLOT_IDX_W-1:0] nearest_slot;
      logic [COORD_W-1:0]    point_x;
      logic [COORD_W-1:0]    point_y;
      logic [COORD_W-1:0]    point_z;
      logic                  found;
   } answer_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [GCOUNT_W-1:0] csr_wdata;

   tlnps_req_if req_bus ();
   tlnps_rsp_if rsp_bus ();

   two_level_nearest_point_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Requests waiting to be driven and answers waiting to arrive
   request_type request_backlog[$];
   answer_type  pending_answers[$];

   // Shadow of the block's tables and of the group count register
   logic [COORD_W-1:0]  anchor_x_tbl [MAX_GROUPS];
   logic [COORD_W-1:0]  anchor_z_tbl [MAX_GROUPS];
   logic [COORD_W-1:0]  point_x_tbl [MAX_GROUPS*MAX_POINTS];
   logic [COORD_W-1:0]  point_y_tbl [MAX_GROUPS*MAX_POINTS];
   logic [COORD_W-1:0]  point_z_tbl [MAX_GROUPS*MAX_POINTS];
   int                  point_count_tbl [MAX_GROUPS];
   logic [GCOUNT_W-1:0] groups_in_use;

   // What the stimulus side has written so far, so no query reads a blank entry
   bit anchor_loaded [MAX_GROUPS];
   int slots_loaded  [MAX_GROUPS];

   int  requests_queued;
   int  requests_taken;
   int  queries_seen;
   int  points_found;
   int  mismatches;
   int  cycle_count;
   bit  no_idle;
   bit  hold_armed;
   int  hold_left;
   bit  hold_done;

   // Exact squared distance; three squares of up to 33-bit differences
   function automatic logic [67:0] dist_sq(logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
                                           logic [COORD_W-1:0] az, logic [COORD_W-1:0] bx,
                                           logic [COORD_W-1:0] by, logic [COORD_W-1:0] bz);
      longint      dx, dy, dz;
      logic [67:0] ux, uy, uz;
      dx = longint'($signed(ax)) - longint'($signed(bx));
      dy = longint'($signed(ay)) - longint'($signed(by));
      dz = longint'($signed(az)) - longint'($signed(bz));
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dz < 0) dz = -dz;
      ux = 68'(dx);
      uy = 68'(dy);
      uz = 68'(dz);
      return ux * ux + uy * uy + uz * uz;
   endfunction

   // Update the shadow tables with one request; queue the answer for a query
   task automatic track_request(request_type r);
      int          n, cnt, base, best_g, best_s;
      logic [67:0] best, d;
      answer_type  a;
      requests_taken++;
      case (r.action)
         ACT_ANCHOR_WR: begin
            anchor_x_tbl[r.group_index] = r.x;
            anchor_z_tbl[r.group_index] = r.z;
         end
         ACT_POINT_WR: begin
            base = r.group_index * MAX_POINTS + r.slot_index;
            point_x_tbl[base] = r.x;
            point_y_tbl[base] = r.y;
            point_z_tbl[base] = r.z;
            point_count_tbl[r.group_index] = r.slot_index + 1;
         end
         ACT_QUERY: begin
            a = '{default: '0};
            n = (groups_in_use > MAX_GROUPS) ? MAX_GROUPS : groups_in_use;
            queries_seen++;
            if (n > 0) begin
               // Nearest anchor, later index wins ties
               best_g = 0;
               best = dist_sq(r.x, r.y, r.z, anchor_x_tbl[0], '0, anchor_z_tbl[0]);
               for (int i = 1; i < n; i++) begin
                  d = dist_sq(r.x, r.y, r.z, anchor_x_tbl[i], '0, anchor_z_tbl[i]);
                  if (d <= best) begin
                     best = d;
                     best_g = i;
                  end
               end
               a.nearest_group = GRP_IDX_W'(best_g);
               cnt = point_count_tbl[best_g];
               if (cnt > 0) begin
                  // Nearest point inside the chosen group
                  base = best_g * MAX_POINTS;
                  best_s = 0;
                  best = dist_sq(r.x, r.y, r.z, point_x_tbl[base], point_y_tbl[base],
                                 point_z_tbl[base]);
                  for (int i = 1; i < cnt; i++) begin
                     d = dist_sq(r.x, r.y, r.z, point_x_tbl[base+i], point_y_tbl[base+i],
                                 point_z_tbl[base+i]);
                     if (d <= best) begin
                        best = d;
                        best_s = i;
                     end
                  end
                  a.nearest_slot = SLOT_IDX_W'(best_s);
                  a.point_x = point_x_tbl[base+best_s];
                  a.point_y = point_y_tbl[base+best_s];
                  a.point_z = point_z_tbl[base+best_s];
                  a.found = 1'b1;
                  points_found++;
               end
            end
            pending_answers = {pending_answers, a};
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string field, logic [COORD_W-1:0] got,
                                  logic [COORD_W-1:0] want);
      $display("[%0t] mismatch on %s: got %h, want %h", $realtime, field, got, want);
      mismatches++;
   endtask

   // Drive requests from the backlog, holding each until it is taken
   always @(posedge clock) begin : drive_requests
      request_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (request_backlog.size() != 0 &&
             (no_idle || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            nxt = request_backlog.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.action      <= nxt.action;
            req_bus.group_index <= nxt.group_index;
            req_bus.slot_index  <= nxt.slot_index;
            req_bus.coord_x     <= nxt.x;
            req_bus.coord_y     <= nxt.y;
            req_bus.coord_z     <= nxt.z;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Accept responses; one long hold-off when armed, random stalls otherwise
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Watch both channels: predict on each request, check each response
   always @(posedge clock) begin : watch_channels
      request_type r;
      answer_type  want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            r.action      = req_bus.action;
            r.group_index = req_bus.group_index;
            r.slot_index  = req_bus.slot_index;
            r.x           = req_bus.coord_x;
            r.y           = req_bus.coord_y;
            r.z           = req_bus.coord_z;
            track_request(r);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("response with no query pending",
                               COORD_W'(rsp_bus.nearest_group), '0);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_bus.nearest_group !== want.nearest_group)
                  report_mismatch("nearest_group", COORD_W'(rsp_bus.nearest_group),
                                  COORD_W'(want.nearest_group));
               if (rsp_bus.nearest_slot !== want.nearest_slot)
                  report_mismatch("nearest_slot", COORD_W'(rsp_bus.nearest_slot),
                                  COORD_W'(want.nearest_slot));
               if (rsp_bus.point_x !== want.point_x)
                  report_mismatch("point_x", rsp_bus.point_x, want.point_x);
               if (rsp_bus.point_y !== want.point_y)
                  report_mismatch("point_y", rsp_bus.point_y, want.point_y);
               if (rsp_bus.point_z !== want.point_z)
                  report_mismatch("point_z", rsp_bus.point_z, want.point_z);
               if (rsp_bus.found !== want.found)
                  report_mismatch("found", COORD_W'(rsp_bus.found), COORD_W'(want.found));
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d answers outstanding", cycle_count,
                  pending_answers.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Queue one request and note what it loads
   task automatic queue_request(logic [ACTION_W-1:0] act, int g, int s,
                                logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                logic [COORD_W-1:0] z);
      request_type r;
      r.action      = act;
      r.group_index = GRP_IDX_W'(g);
      r.slot_index  = SLOT_IDX_W'(s);
      r.x           = x;
      r.y           = y;
      r.z           = z;
      if (act == ACT_ANCHOR_WR) anchor_loaded[g] = 1'b1;
      if (act == ACT_POINT_WR && s == slots_loaded[g]) slots_loaded[g]++;
      request_backlog = {request_backlog, r};
      requests_queued++;
   endtask

   // Mostly a tight cluster so groups compete, with tiny values for ties
   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom();
         2: begin
            case ($urandom_range(0, 3))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'hFFFF_FFFF;
               default: return 32'h0000_0000;
            endcase
         end
         3:       return $urandom_range(0, 8) - 4;
         default: return $urandom_range(0, 131072) - 65536;
      endcase
   endfunction

   task automatic wait_drained();
      while (requests_taken != requests_queued || pending_answers.size() != 0)
         @(posedge clock);
   endtask

   // Let a trailing write finish before touching the register
   task automatic settle_idle();
      wait_drained();
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic set_group_count(logic [GCOUNT_W-1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      groups_in_use = v;
   endtask

   // Random mix of writes and queries over the groups in use
   task automatic queue_random(int count, int n);
      int done, r, g, s;
      done = 0;
      while (done < count) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            queue_request(ACT_ANCHOR_WR, $urandom_range(0, MAX_GROUPS-1), 0,
                          pick_coord(), $urandom(), pick_coord());
            done++;
         end else if (r < 42) begin
            if (n > 0 && $urandom_range(0, 4) != 0) g = $urandom_range(0, n-1);
            else g = $urandom_range(0, MAX_GROUPS-1);
            // Grow the loaded prefix mostly; rewrite inside it to shrink the count
            if (slots_loaded[g] < MAX_POINTS && $urandom_range(0, 9) < 7)
               s = slots_loaded[g];
            else if (slots_loaded[g] < MAX_POINTS)
               s = $urandom_range(0, slots_loaded[g]);
            else
               s = $urandom_range(0, MAX_POINTS-1);
            queue_request(ACT_POINT_WR, g, s, pick_coord(), pick_coord(), pick_coord());
            done++;
         end else if (r < 95) begin
            queue_request(ACT_QUERY, $urandom_range(0, MAX_GROUPS-1),
                          $urandom_range(0, MAX_POINTS-1),
                          pick_coord(), pick_coord(), pick_coord());
            done++;
         end else begin
            queue_request(ACT_UNUSED, $urandom_range(0, MAX_GROUPS-1),
                          $urandom_range(0, MAX_POINTS-1), $urandom(), $urandom(), $urandom());
         end
      end
   endtask

   initial begin
      logic [GCOUNT_W-1:0] settings [8];
      int n;

      // Hold every input at a known value from time zero
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.action      = '0;
      req_bus.group_index = '0;
      req_bus.slot_index  = '0;
      req_bus.coord_x     = '0;
      req_bus.coord_y     = '0;
      req_bus.coord_z     = '0;
      rsp_bus.ready       = 1'b0;
      groups_in_use       = '0;
      cycle_count         = 0;
      no_idle             = 1'b0;
      hold_armed          = 1'b0;
      requests_queued     = 0;
      requests_taken      = 0;
      queries_seen        = 0;
      points_found        = 0;
      mismatches          = 0;
      for (int g = 0; g < MAX_GROUPS; g++) begin
         anchor_x_tbl[g]    = '0;
         anchor_z_tbl[g]    = '0;
         point_count_tbl[g] = 0;
         anchor_loaded[g]   = 1'b0;
         slots_loaded[g]    = 0;
      end
      for (int k = 0; k < MAX_GROUPS*MAX_POINTS; k++) begin
         point_x_tbl[k] = '0;
         point_y_tbl[k] = '0;
         point_z_tbl[k] = '0;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty table: no groups in use after reset
      queue_request(ACT_QUERY, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      queue_request(ACT_ANCHOR_WR, MAX_GROUPS-1, 0, 32'h10, 32'hFFFF_FFFF, 32'h20);
      queue_request(ACT_POINT_WR, MAX_GROUPS-1, 0, 32'h1, 32'h2, 32'h3);
      settle_idle();
      set_group_count(GCOUNT_W'(2));

      // Equal anchors: later group wins, and it is still empty
      queue_request(ACT_ANCHOR_WR, 0, 0, 32'd100, 32'd0, -32'sd100);
      queue_request(ACT_ANCHOR_WR, 1, 0, 32'd100, 32'h1234_5678, -32'sd100);
      queue_request(ACT_QUERY, 0, 0, 32'd100, 32'd0, -32'sd100);
      // Equal points plus the coordinate extremes
      queue_request(ACT_POINT_WR, 1, 0, 32'd5, 32'd7, 32'd9);
      queue_request(ACT_POINT_WR, 1, 1, 32'd5, 32'd7, 32'd9);
      queue_request(ACT_POINT_WR, 1, 2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_request(ACT_POINT_WR, 1, 3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_request(ACT_QUERY, 0, 0, 32'd5, 32'd7, 32'd9);
      queue_request(ACT_QUERY, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_request(ACT_QUERY, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_request(ACT_UNUSED, MAX_GROUPS-1, MAX_POINTS-1, '1, '1, '1);
      // Rewrite of slot zero drops the group back to one point
      queue_request(ACT_POINT_WR, 1, 0, 32'd1, 32'd1, 32'd1);
      queue_request(ACT_QUERY, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      // Move group zero closer: chosen group holds no points
      queue_request(ACT_ANCHOR_WR, 0, 0, -32'sd3000, 32'd0, 32'd3000);
      queue_request(ACT_QUERY, 0, 0, -32'sd3000, 32'd0, 32'd3000);

      settings[0] = 7'd64;
      settings[1] = 7'd0;
      settings[2] = 7'd1;
      settings[3] = 7'd127;
      settings[4] = GCOUNT_W'($urandom_range(3, 63));
      settings[5] = 7'd64;
      settings[6] = GCOUNT_W'($urandom_range(65, 126));
      settings[7] = 7'd2;

      for (int p = 0; p < 8; p++) begin
         settle_idle();
         no_idle = (p == 5);
         set_group_count(settings[p]);
         n = (settings[p] > MAX_GROUPS) ? MAX_GROUPS : settings[p];
         // Load every anchor the search will read
         for (int g = 0; g < n; g++)
            if (!anchor_loaded[g])
               queue_request(ACT_ANCHOR_WR, g, 0, pick_coord(), $urandom(), pick_coord());
         // Stall the receiver long enough for the block to back up
         if (p == 0) hold_armed = 1'b1;
         if (p == 3) begin
            queue_random(PHASE_ITEMS / 2, n);
            wait_drained();
            queue_random(PHASE_ITEMS - PHASE_ITEMS / 2, n);
         end else begin
            queue_random(PHASE_ITEMS, n);
         end
      end

      settle_idle();
      no_idle = 1'b0;
      $display("Covered %0d requests over 8 group-count settings: %0d queries, %0d found a point.",
               requests_taken, queries_seen, points_found);
      $display("Responses checked with %0d mismatches.", mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
